// File: src/source_failover_backoff_assert.svh
// Assertion macros for the source failover backoff block.
// Needs a clock and an active-high reset in scope at the point of use.
`ifndef SOURCE_FAILOVER_BACKOFF_ASSERT_SVH
`define SOURCE_FAILOVER_BACKOFF_ASSERT_SVH

// Same-cycle implication.
`define SFB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sfb assertion failed");

// Next-cycle implication.
`define SFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sfb assertion failed");

`endif

// File: src/sfb_pkg.sv
// Constants, codes and helpers for the source failover backoff block.
// No dependencies.
package sfb_pkg;

  localparam int MAX_SOURCES      = 16;
  localparam int MAX_BACKOFF_DAYS = 16;
  localparam int MAX_FUZZ_MINUTES = 720;

  localparam int SOURCE_SLOTS    = 16;
  localparam int MINUTES_PER_DAY = 24 * 60;

  localparam int LIVE_CAP = (MAX_SOURCES < SOURCE_SLOTS) ? MAX_SOURCES : SOURCE_SLOTS;
  localparam int DAYS_W   = $clog2(MAX_BACKOFF_DAYS + 1);
  localparam int MIN_W    = $clog2(MAX_BACKOFF_DAYS * MINUTES_PER_DAY + 1);
  localparam int FUZZ_W   = $clog2(MAX_FUZZ_MINUTES + 1024);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [2:0] {
    CMD_CHECK    = 3'd0,
    CMD_DONE     = 3'd1,
    CMD_PROGRESS = 3'd2,
    CMD_FAILURE  = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CLS_SOURCE    = 2'd0,
    CLS_TRANSIENT = 2'd1,
    CLS_NEUTRAL   = 2'd2
  } err_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_COUNT   = 3'd0,
    REG_MAX_FAILURES   = 3'd1,
    REG_BACKOFF_OFF    = 3'd2,
    REG_DELTA_PAYLOAD  = 3'd3,
    REG_OFFICIAL_BUILD = 3'd4
  } cfg_reg_t;

  // Backoff length in minutes for attempt count n (n >= 1):
  // min(2^(n-1), MAX_BACKOFF_DAYS) days.
  function automatic logic [MIN_W-1:0] backoff_minutes(input logic [31:0] attempts);
    logic [31:0]       power;
    logic [DAYS_W-1:0] pow_days;
    logic [DAYS_W-1:0] days;
    power    = attempts - 32'd1;
    pow_days = DAYS_W'(1) << power;
    if (power >= 32'(DAYS_W) || pow_days > DAYS_W'(MAX_BACKOFF_DAYS)) begin
      days = DAYS_W'(MAX_BACKOFF_DAYS);
    end else begin
      days = pow_days;
    end
    return MIN_W'(days * MINUTES_PER_DAY);
  endfunction

endpackage

// File: src/sfb_if.sv
// Valid/ready channels for event words in and result words out.
// Depends on nothing; widths are fixed by the word fields.
interface sfb_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic        response_changed;
  logic [31:0] progress_bytes;
  logic [1:0]  error_class;
  logic [39:0] now_minutes;
  logic [9:0]  jitter_minutes;

  modport source (output valid, command, response_changed, progress_bytes,
                  error_class, now_minutes, jitter_minutes, input ready);
  modport sink   (input valid, command, response_changed, progress_bytes,
                  error_class, now_minutes, jitter_minutes, output ready);
endinterface

interface sfb_rsp_if;
  logic        valid;
  logic        ready;
  logic        backoff_wait;
  logic [3:0]  source_now;
  logic [7:0]  failures_now;
  logic [31:0] attempts_now;
  logic [40:0] expiry_now;

  modport source (output valid, backoff_wait, source_now, failures_now,
                  attempts_now, expiry_now, input ready);
  modport sink   (input valid, backoff_wait, source_now, failures_now,
                  attempts_now, expiry_now, output ready);
endinterface

// File: src/source_failover_backoff.sv
// Retry controller with source failover and capped exponential backoff.
// Depends on sfb_pkg, sfb_if.sv and source_failover_backoff_assert.svh.
//
// Usage:
//   req carries one event word (check, done, progress, failure, query) with
//   the current time and a jitter value. rsp returns one result word per
//   event: wait flag, source index, failure count, attempt count, expiry.
//   cfg_we/cfg_index/cfg_data write the five control registers; write them
//   only while no event is in flight.
// Timing:
//   An event word is first captured in the input register; the state update and
//   the result register load happen together when it advances out of the input
//   register, and the result word is then valid in the result register.
//   One event per cycle is sustained while rsp.ready is high; the state
//   registers close the loop between consecutive events.
// Reset:
//   rst (synchronous) clears the pipeline, zeroes all retry state and loads
//   the register defaults (10 failures per source, official build).
// Stall:
//   While rsp is held off, the result register keeps its word and the input
//   register fills; req.ready then drops until rsp.ready returns.
module source_failover_backoff (
  input  logic                          clk,
  input  logic                          rst,
  sfb_req_if.sink                       req,
  sfb_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfb_pkg::*;

  // control registers
  logic [4:0] source_count;
  logic [7:0] max_failures;
  logic       backoff_off;
  logic       delta_payload;
  logic       official_build;

  // retry state
  logic [3:0]  cur_source;
  logic [7:0]  failures;
  logic [31:0] attempts;
  logic [40:0] expiry;

  // input register
  logic        s1_valid;
  logic [2:0]  s1_command;
  logic        s1_changed;
  logic        s1_bytes_nz;
  logic [1:0]  s1_class;
  logic [39:0] s1_now;
  logic [9:0]  s1_fuzz;

  // result register
  logic        out_valid;
  logic        out_wait;
  logic [3:0]  out_source;
  logic [7:0]  out_failures;
  logic [31:0] out_attempts;
  logic [40:0] out_expiry;

  logic req_fire;
  logic advance;

  logic [4:0]        live;
  logic [4:0]        src_inc;
  logic [8:0]        fail_inc;
  logic [31:0]       att_inc;
  logic [FUZZ_W-1:0] fuzz_sat;
  logic [40:0]       arm_exp;
  logic              adv_src;
  logic              do_attempt;

  logic [3:0]  cur_source_next;
  logic [7:0]  failures_next;
  logic [31:0] attempts_next;
  logic [40:0] expiry_next;
  logic        wait_next;

  assign advance  = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign req_fire = req.valid && req.ready;

  assign rsp.valid        = out_valid;
  assign rsp.backoff_wait = out_wait;
  assign rsp.source_now   = out_source;
  assign rsp.failures_now = out_failures;
  assign rsp.attempts_now = out_attempts;
  assign rsp.expiry_now   = out_expiry;

  always_comb begin
    live     = (source_count > 5'(LIVE_CAP)) ? 5'(LIVE_CAP) : source_count;
    src_inc  = {1'b0, cur_source} + 5'd1;
    fail_inc = {1'b0, failures} + 9'd1;
    att_inc  = (attempts == 32'hFFFF_FFFF) ? attempts : attempts + 32'd1;
    fuzz_sat = ({1'b0, s1_fuzz} > FUZZ_W'(MAX_FUZZ_MINUTES)) ?
               FUZZ_W'(MAX_FUZZ_MINUTES) : FUZZ_W'(s1_fuzz);
    arm_exp  = backoff_off ? 41'd0 :
               41'(s1_now) + 41'(backoff_minutes(att_inc)) + 41'(fuzz_sat);

    cur_source_next = cur_source;
    failures_next   = failures;
    attempts_next   = attempts;
    expiry_next     = expiry;
    adv_src         = 1'b0;
    do_attempt      = 1'b0;

    case (s1_command)
      CMD_CHECK: begin
        if (s1_changed || {1'b0, cur_source} >= live) begin
          cur_source_next = '0;
          failures_next   = '0;
          attempts_next   = '0;
          expiry_next     = '0;
        end
      end
      CMD_DONE: begin
        do_attempt = 1'b1;
      end
      CMD_PROGRESS: begin
        if (s1_bytes_nz) begin
          failures_next = '0;
        end
      end
      CMD_FAILURE: begin
        if (live != 5'd0) begin
          case (s1_class)
            CLS_SOURCE: begin
              adv_src = 1'b1;
            end
            CLS_TRANSIENT: begin
              if (fail_inc < {1'b0, max_failures}) begin
                failures_next = fail_inc[7:0];
              end else begin
                adv_src = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase

    if (adv_src) begin
      failures_next = '0;
      if (src_inc < live) begin
        cur_source_next = src_inc[3:0];
      end else begin
        cur_source_next = '0;
        do_attempt      = 1'b1;
      end
    end

    if (do_attempt && !delta_payload) begin
      attempts_next = att_inc;
      expiry_next   = arm_exp;
    end

    wait_next = !backoff_off && !delta_payload && official_build &&
                (expiry_next != 41'd0) && (expiry_next >= {1'b0, s1_now});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      source_count   <= '0;
      max_failures   <= 8'd10;
      backoff_off    <= 1'b0;
      delta_payload  <= 1'b0;
      official_build <= 1'b1;
      cur_source     <= '0;
      failures       <= '0;
      attempts       <= '0;
      expiry         <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SOURCE_COUNT:   source_count   <= cfg_data[4:0];
          REG_MAX_FAILURES:   max_failures   <= cfg_data[7:0];
          REG_BACKOFF_OFF:    backoff_off    <= cfg_data[0];
          REG_DELTA_PAYLOAD:  delta_payload  <= cfg_data[0];
          REG_OFFICIAL_BUILD: official_build <= cfg_data[0];
          default: ;
        endcase
      end
      if (req_fire) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        cur_source <= cur_source_next;
        failures   <= failures_next;
        attempts   <= attempts_next;
        expiry     <= expiry_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      s1_command  <= req.command;
      s1_changed  <= req.response_changed;
      s1_bytes_nz <= (req.progress_bytes != 32'd0);
      s1_class    <= req.error_class;
      s1_now      <= req.now_minutes;
      s1_fuzz     <= req.jitter_minutes;
    end
    if (advance) begin
      out_wait     <= wait_next;
      out_source   <= cur_source_next;
      out_failures <= failures_next;
      out_attempts <= attempts_next;
      out_expiry   <= expiry_next;
    end
  end

  `include "source_failover_backoff_assert.svh"

  `SFB_ASSERT_NOW(a_wait_needs_expiry, clk, rst, out_valid && out_wait, out_expiry != 41'd0)
  `SFB_ASSERT_NOW(a_ready_when_empty, clk, rst, !s1_valid, req.ready)
  `SFB_ASSERT_NEXT(a_change_clears, clk, rst, advance && s1_command == CMD_CHECK && s1_changed, attempts == 32'd0 && expiry == 41'd0 && cur_source == 4'd0)
  `SFB_ASSERT_NEXT(a_attempts_monotonic, clk, rst, advance && s1_command != CMD_CHECK, attempts >= $past(attempts))
  `SFB_ASSERT_NEXT(a_result_tracks_state, clk, rst, advance, out_valid && out_attempts == attempts && out_expiry == expiry)

endmodule
